[rtl/core/srtf_pkg.sv]
// Package: shared constants, item types and helpers for the SRTF scheduler.
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int TIME_WIDTH = 16;
    localparam int IDX_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    localparam time_t TIME_MAX = '1;

    typedef struct packed {
        logic        action;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
    } cmd_t;

    typedef struct packed {
        logic        load_rejected;
        logic        idle;
        logic [4:0]  task_id;
        logic        finished;
        logic [15:0] completion_time;
        logic [15:0] turnaround_time;
        logic [15:0] waiting_time;
        logic [15:0] response_time;
        logic        all_done;
    } res_t;

    // Key of one task as seen by the selection compare.
    typedef struct packed {
        time_t remaining;
        time_t arrival;
    } sel_key_t;

    // Clamp a 16-bit input time into the scheduler's time range.
    function automatic time_t sat_time(input logic [15:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 > 32'(TIME_MAX))
            return TIME_MAX;
        return time_t'(v32);
    endfunction

endpackage

[rtl/core/srtf_cmp.sv]
// Selection compare: is a candidate task a better pick than the current best.
`timescale 1ns / 1ps

module srtf_cmp
    import srtf_pkg::*;
(
    input  sel_key_t cand,
    input  sel_key_t best,
    input  logic     has_best,
    output logic     better
);

    // Less remaining time wins; on a tie, the earlier arrival wins.
    // Equal keys keep the lower slot, which was seen first.
    always_comb
    begin
        better = !has_best
              || (cand.remaining < best.remaining)
              || ((cand.remaining == best.remaining) && (cand.arrival < best.arrival));
    end

endmodule

[rtl/core/shortest_remaining_time_scheduler.sv]
// Top level: preemptive shortest-remaining-time-first scheduler with a task table.
`timescale 1ns / 1ps

// A load item puts a task (arrival, burst) into the next free slot of a
// MAX_TASKS-entry table and returns its result on the next clock edge; a full
// table rejects it. A tick item scans the loaded slots one per cycle through a
// single shared compare unit, picks the ready task with the least remaining
// time (earlier arrival, then lower slot on ties), runs it for one time unit
// and reports it, with completion statistics when it finishes. A tick reads
// each loaded slot through a registered table read, drains the last read,
// then updates the chosen task and registers its result. cmd_ready is low
// while a tick is in work, and an item is taken only when the result
// register is empty or being emptied in the same cycle. Time saturates at
// its maximum; a burst of zero counts as one.

module shortest_remaining_time_scheduler
    import srtf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL
    } state_t;

    // Task table, one write and one read port each.
    time_t arrival_mem   [MAX_TASKS];
    time_t burst_mem     [MAX_TASKS];
    time_t remaining_mem [MAX_TASKS];
    time_t start_mem     [MAX_TASKS];

    state_t                 state_reg,    state_next;
    logic [MAX_TASKS-1:0]   done_reg,     done_next;
    cnt_t                   task_cnt_reg, task_cnt_next;
    cnt_t                   fin_cnt_reg,  fin_cnt_next;
    time_t                  time_reg,     time_next;
    cnt_t                   scan_reg,     scan_next;
    logic                   cmp_vld_reg,  cmp_vld_next;
    idx_t                   cmp_idx_reg,  cmp_idx_next;
    logic                   has_pick_reg, has_pick_next;
    idx_t                   best_idx_reg, best_idx_next;
    time_t                  best_arr_reg, best_arr_next;
    time_t                  best_bur_reg, best_bur_next;
    time_t                  best_rem_reg, best_rem_next;
    time_t                  best_sta_reg, best_sta_next;
    logic                   res_vld_reg,  res_vld_next;
    res_t                   res_reg,      res_next;

    // Registered table read data.
    time_t rd_arr_reg;
    time_t rd_bur_reg;
    time_t rd_rem_reg;
    time_t rd_sta_reg;

    logic  accept;
    logic  rd_en;
    idx_t  rd_addr;
    logic  load_we;
    logic  rem_we;
    logic  sta_we;
    idx_t  wr_addr;
    time_t load_arr;
    time_t load_bur;
    time_t rem_wdata;
    time_t sta_wdata;

    sel_key_t cand_key;
    sel_key_t best_key;
    logic     cand_better;
    logic     cand_ready;

    // Update-step arithmetic.
    time_t rem_dec;
    time_t time_inc;
    time_t run_start;
    time_t tat;
    time_t wt;
    logic  first_run;

    assign cmd_ready = (state_reg == ST_IDLE) && (!res_vld_reg || res_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    assign rd_addr = scan_reg[IDX_W-1:0];
    assign rd_en   = (state_reg == ST_SCAN) && (scan_reg < task_cnt_reg);

    assign cand_key.remaining = rd_rem_reg;
    assign cand_key.arrival   = rd_arr_reg;
    assign best_key.remaining = best_rem_reg;
    assign best_key.arrival   = best_arr_reg;

    // Shared compare unit: one slot per cycle.
    srtf_cmp u_cmp (
        .cand     (cand_key),
        .best     (best_key),
        .has_best (has_pick_reg),
        .better   (cand_better)
    );

    assign cand_ready = cmp_vld_reg && !done_reg[cmp_idx_reg] && (rd_arr_reg <= time_reg);

    always_comb
    begin
        load_arr  = sat_time(cmd.arrival_time);
        load_bur  = sat_time(cmd.burst_time);
        if (load_bur == '0)
            load_bur = time_t'(1);

        rem_dec   = best_rem_reg - time_t'(1);
        time_inc  = (time_reg == TIME_MAX) ? time_reg : time_reg + time_t'(1);
        first_run = (best_rem_reg == best_bur_reg);
        run_start = first_run ? time_reg : best_sta_reg;
        tat       = time_inc - best_arr_reg;
        wt        = (tat >= best_bur_reg) ? tat - best_bur_reg : '0;
    end

    always_comb
    begin
        state_next    = state_reg;
        done_next     = done_reg;
        task_cnt_next = task_cnt_reg;
        fin_cnt_next  = fin_cnt_reg;
        time_next     = time_reg;
        scan_next     = scan_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        has_pick_next = has_pick_reg;
        best_idx_next = best_idx_reg;
        best_arr_next = best_arr_reg;
        best_bur_next = best_bur_reg;
        best_rem_next = best_rem_reg;
        best_sta_next = best_sta_reg;
        res_vld_next  = res_vld_reg && !res_ready;
        res_next      = res_reg;

        load_we   = 1'b0;
        rem_we    = 1'b0;
        sta_we    = 1'b0;
        wr_addr   = task_cnt_reg[IDX_W-1:0];
        rem_wdata = load_bur;
        sta_wdata = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_LOAD)
                    begin
                        res_next     = '0;
                        res_vld_next = 1'b1;
                        if (task_cnt_reg >= cnt_t'(MAX_TASKS))
                        begin
                            res_next.load_rejected = 1'b1;
                            res_next.all_done      = (fin_cnt_reg == task_cnt_reg);
                        end
                        else
                        begin
                            load_we   = 1'b1;
                            rem_we    = 1'b1;
                            sta_we    = 1'b1;
                            done_next[task_cnt_reg[IDX_W-1:0]] = 1'b0;
                            task_cnt_next = task_cnt_reg + cnt_t'(1);
                            res_next.all_done = (fin_cnt_reg == task_cnt_next);
                        end
                    end
                    else
                    begin
                        scan_next     = '0;
                        has_pick_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the read of the next slot.
                if (rd_en)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_addr;
                    scan_next    = scan_reg + cnt_t'(1);
                end
                else
                begin
                    state_next = ST_EVAL;
                end
                // Compare the slot read last cycle.
                if (cand_ready && cand_better)
                begin
                    has_pick_next = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_arr_next = rd_arr_reg;
                    best_bur_next = rd_bur_reg;
                    best_rem_next = rd_rem_reg;
                    best_sta_next = rd_sta_reg;
                end
            end

            ST_EVAL:
            begin
                res_next     = '0;
                res_vld_next = 1'b1;
                time_next    = time_inc;
                state_next   = ST_IDLE;
                if (!has_pick_reg)
                begin
                    res_next.idle     = 1'b1;
                    res_next.all_done = (fin_cnt_reg == task_cnt_reg);
                end
                else
                begin
                    wr_addr   = best_idx_reg;
                    rem_we    = 1'b1;
                    rem_wdata = rem_dec;
                    sta_we    = first_run;
                    sta_wdata = time_reg;
                    res_next.task_id = 5'(best_idx_reg) + 5'd1;
                    if (rem_dec == '0)
                    begin
                        done_next[best_idx_reg]   = 1'b1;
                        fin_cnt_next              = fin_cnt_reg + cnt_t'(1);
                        res_next.finished         = 1'b1;
                        res_next.completion_time  = 16'(time_inc);
                        res_next.turnaround_time  = 16'(tat);
                        res_next.waiting_time     = 16'(wt);
                        res_next.response_time    = 16'(run_start - best_arr_reg);
                    end
                    res_next.all_done = (fin_cnt_next == task_cnt_reg);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= '0;
            task_cnt_reg <= '0;
            fin_cnt_reg  <= '0;
            time_reg     <= '0;
            scan_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            has_pick_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            task_cnt_reg <= task_cnt_next;
            fin_cnt_reg  <= fin_cnt_next;
            time_reg     <= time_next;
            scan_reg     <= scan_next;
            cmp_vld_reg  <= cmp_vld_next;
            has_pick_reg <= has_pick_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_arr_reg <= best_arr_next;
        best_bur_reg <= best_bur_next;
        best_rem_reg <= best_rem_next;
        best_sta_reg <= best_sta_next;
        res_reg      <= res_next;
    end

    // Task table writes.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            arrival_mem[wr_addr] <= load_arr;
            burst_mem[wr_addr]   <= load_bur;
        end
        if (rem_we)
            remaining_mem[wr_addr] <= rem_wdata;
        if (sta_we)
            start_mem[wr_addr] <= sta_wdata;
    end

    // Task table reads, registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_arr_reg <= arrival_mem[rd_addr];
            rd_bur_reg <= burst_mem[rd_addr];
            rd_rem_reg <= remaining_mem[rd_addr];
            rd_sta_reg <= start_mem[rd_addr];
        end
    end

endmodule

[rtl/core/srtf_checker.sv]
// Port checker for the SRTF scheduler, bound to the top level.
`timescale 1ns / 1ps

module srtf_checker
    import srtf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input cmd_t cmd,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // A stalled result holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // An accepted tick keeps the block busy for the next cycle.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.action == ACT_TICK) |=> !cmd_ready)
        else $error("ready right after a tick");

    // An idle tick names no task.
    a_idle_none: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.idle |-> (res.task_id == 5'd0) && !res.finished
                                  && !res.load_rejected)
        else $error("idle result carries a task");

    // A finished task always has an id within the table.
    a_fin_id: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.finished |->
            (res.task_id != 5'd0) && (32'(res.task_id) <= 32'(MAX_TASKS)) && !res.idle)
        else $error("finished result without a valid task id");

    // A rejected load reports no run.
    a_rej_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.load_rejected |-> (res.task_id == 5'd0) && !res.finished)
        else $error("rejected load carries a run");

endmodule

bind shortest_remaining_time_scheduler srtf_checker u_srtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
